FILE: design/ptwp_pkg.sv
// ----------------------------------------------------------------------------
// ptwp_pkg
// Shared types and constants for the prescaled timer with PWM outputs.
// ----------------------------------------------------------------------------
`default_nettype none

package ptwp_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  localparam logic [3:0] REG_CTRL   = 4'd0;
  localparam logic [3:0] REG_IER    = 4'd1;
  localparam logic [3:0] REG_STATUS = 4'd2;
  localparam logic [3:0] REG_EVENT  = 4'd3;
  localparam logic [3:0] REG_CCMODE = 4'd4;
  localparam logic [3:0] REG_CCEN   = 4'd5;
  localparam logic [3:0] REG_COUNT  = 4'd6;
  localparam logic [3:0] REG_PSC    = 4'd7;
  localparam logic [3:0] REG_RELOAD = 4'd8;
  localparam logic [3:0] REG_CMP1   = 4'd9;
  localparam logic [3:0] REG_CMP2   = 4'd10;

  localparam logic [2:0] MODE_FORCE_LOW  = 3'd4;
  localparam logic [2:0] MODE_FORCE_HIGH = 3'd5;
  localparam logic [2:0] MODE_PWM1       = 3'd6;
  localparam logic [2:0] MODE_PWM2       = 3'd7;

  typedef struct packed {
    logic [15:0] write_data;
    logic [3:0]  reg_index;
    kind_e       kind;
  } item_t;

  typedef struct packed {
    logic        update_pulse;
    logic        pwm_two;
    logic        pwm_one;
    logic        irq;
    logic [15:0] read_data;
  } result_t;

  function automatic logic chan_level(logic [2:0] mode, logic active);
    logic lvl;
    unique case (mode)
      MODE_FORCE_LOW:  lvl = 1'b0;
      MODE_FORCE_HIGH: lvl = 1'b1;
      MODE_PWM1:       lvl = active;
      MODE_PWM2:       lvl = ~active;
      default:         lvl = 1'b0;
    endcase
    return lvl;
  endfunction

endpackage

`default_nettype wire

FILE: design/ptwp_stage.sv
// ----------------------------------------------------------------------------
// ptwp_stage
// One valid/ready register slice; loads whenever empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwp_stage #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output logic [WIDTH-1:0]      data_o
);

  logic             valid_q;
  logic [WIDTH-1:0] data_q;

  assign ready_o = ~valid_q | ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/ptwp_core.sv
// ----------------------------------------------------------------------------
// ptwp_core
// Timer state, register file and per-item next-state / result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwp_core
  import ptwp_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire item_t item_i,
  output result_t    result_o
);

  localparam int unsigned CW = COUNTER_WIDTH;

  logic          run_q, run_d, opm_q, opm_d, down_q, down_d;
  logic          ie_q, ie_d, flag_q, flag_d;
  logic [2:0]    mode1_q, mode1_d, mode2_q, mode2_d;
  logic          en1_q, en1_d, en2_q, en2_d;
  logic [CW-1:0] cnt_q, cnt_d, reload_q, reload_d;
  logic [CW-1:0] cmp1_q, cmp1_d, cmp2_q, cmp2_d;
  logic [15:0]   ps_cnt_q, ps_cnt_d, ps_act_q, ps_act_d, ps_pre_q, ps_pre_d;
  logic          upd;
  logic [15:0]   rd;
  logic [31:0]   wd32, rd32;
  logic [15:0]   wd;
  logic          act1, act2;

  assign wd   = item_i.write_data;
  assign wd32 = {16'b0, wd};

  always_comb begin
    run_d    = run_q;
    opm_d    = opm_q;
    down_d   = down_q;
    ie_d     = ie_q;
    flag_d   = flag_q;
    mode1_d  = mode1_q;
    mode2_d  = mode2_q;
    en1_d    = en1_q;
    en2_d    = en2_q;
    cnt_d    = cnt_q;
    reload_d = reload_q;
    cmp1_d   = cmp1_q;
    cmp2_d   = cmp2_q;
    ps_cnt_d = ps_cnt_q;
    ps_act_d = ps_act_q;
    ps_pre_d = ps_pre_q;
    upd      = 1'b0;
    rd32     = 32'b0;
    if (step_i) begin
      unique case (item_i.kind)
        KIND_TICK: begin
          if (run_q) begin
            if (ps_cnt_q < ps_act_q) begin
              ps_cnt_d = ps_cnt_q + 16'd1;
            end else begin
              ps_cnt_d = '0;
              if (down_q) begin
                if (cnt_q == '0) begin
                  cnt_d = reload_q;
                  upd   = 1'b1;
                end else begin
                  cnt_d = cnt_q - CW'(1);
                end
              end else begin
                if (cnt_q >= reload_q) begin
                  cnt_d = '0;
                  upd   = 1'b1;
                end else begin
                  cnt_d = cnt_q + CW'(1);
                end
              end
              if (upd) begin
                ps_act_d = ps_pre_q;
                flag_d   = 1'b1;
                if (opm_q) begin
                  run_d = 1'b0;
                end
              end
            end
          end
        end
        KIND_WRITE: begin
          unique case (item_i.reg_index)
            REG_CTRL: begin
              run_d  = wd[0];
              opm_d  = wd[3];
              down_d = wd[4];
            end
            REG_IER:    ie_d   = wd[0];
            REG_STATUS: flag_d = flag_q & wd[0];
            REG_EVENT: begin
              if (wd[0]) begin
                cnt_d    = down_q ? reload_q : '0;
                ps_cnt_d = '0;
                ps_act_d = ps_pre_q;
                flag_d   = 1'b1;
                upd      = 1'b1;
              end
            end
            REG_CCMODE: begin
              mode1_d = wd[6:4];
              mode2_d = wd[14:12];
            end
            REG_CCEN: begin
              en1_d = wd[0];
              en2_d = wd[4];
            end
            REG_COUNT:  cnt_d    = wd32[CW-1:0];
            REG_PSC:    ps_pre_d = wd;
            REG_RELOAD: reload_d = wd32[CW-1:0];
            REG_CMP1:   cmp1_d   = wd32[CW-1:0];
            REG_CMP2:   cmp2_d   = wd32[CW-1:0];
            default: ;
          endcase
        end
        KIND_READ: begin
          unique case (item_i.reg_index)
            REG_CTRL:   rd32 = {27'b0, down_q, opm_q, 2'b0, run_q};
            REG_IER:    rd32 = {31'b0, ie_q};
            REG_STATUS: rd32 = {31'b0, flag_q};
            REG_CCMODE: rd32 = {17'b0, mode2_q, 5'b0, mode1_q, 4'b0};
            REG_CCEN:   rd32 = {27'b0, en2_q, 3'b0, en1_q};
            REG_COUNT:  rd32 = 32'(cnt_q);
            REG_PSC:    rd32 = {16'b0, ps_pre_q};
            REG_RELOAD: rd32 = 32'(reload_q);
            REG_CMP1:   rd32 = 32'(cmp1_q);
            REG_CMP2:   rd32 = 32'(cmp2_q);
            default:    rd32 = 32'b0;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign rd   = rd32[15:0];
  assign act1 = down_d ? (cnt_d <= cmp1_d) : (cnt_d < cmp1_d);
  assign act2 = down_d ? (cnt_d <= cmp2_d) : (cnt_d < cmp2_d);

  always_comb begin
    result_o.read_data    = rd;
    result_o.irq          = flag_d & ie_d;
    result_o.pwm_one      = en1_d & chan_level(mode1_d, act1);
    result_o.pwm_two      = en2_d & chan_level(mode2_d, act2);
    result_o.update_pulse = upd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q    <= 1'b0;
      opm_q    <= 1'b0;
      down_q   <= 1'b0;
      ie_q     <= 1'b0;
      flag_q   <= 1'b0;
      mode1_q  <= '0;
      mode2_q  <= '0;
      en1_q    <= 1'b0;
      en2_q    <= 1'b0;
      cnt_q    <= '0;
      reload_q <= '1;
      cmp1_q   <= '0;
      cmp2_q   <= '0;
      ps_cnt_q <= '0;
      ps_act_q <= '0;
      ps_pre_q <= '0;
    end else begin
      run_q    <= run_d;
      opm_q    <= opm_d;
      down_q   <= down_d;
      ie_q     <= ie_d;
      flag_q   <= flag_d;
      mode1_q  <= mode1_d;
      mode2_q  <= mode2_d;
      en1_q    <= en1_d;
      en2_q    <= en2_d;
      cnt_q    <= cnt_d;
      reload_q <= reload_d;
      cmp1_q   <= cmp1_d;
      cmp2_q   <= cmp2_d;
      ps_cnt_q <= ps_cnt_d;
      ps_act_q <= ps_act_d;
      ps_pre_q <= ps_pre_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/prescaled_timer_with_pwm_core.sv
// ----------------------------------------------------------------------------
// prescaled_timer_with_pwm_core
// General purpose timer with prescaler, reload and two PWM compare channels.
//
// Usage:
//   The slave stream carries one operation per transfer: tuser selects a
//   timer tick, a register write or a register read; tdata carries the
//   register index and write value. Every operation yields exactly one
//   master-stream transfer with read data, irq, both PWM levels and the
//   update-event flag, all showing the state after that operation.
//   The operation lands in the input register, is evaluated by the timer
//   logic and lands in the result register. Throughput is one operation
//   per cycle while the master side accepts results, set by the
//   combinational counter/compare path between the two registers.
//   A stalled master side holds the result register; one more operation can
//   still be taken into the input register before s_axis_tready drops.
//   Reset empties both registers, stops the counter, counts up and sets the
//   reload value to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module prescaled_timer_with_pwm_core
  import ptwp_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // reg_index[3:0], write_data[19:4], zero pad
  input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // read_data[15:0], irq[16], pwm_one[17],
                                          // pwm_two[18], update_pulse[19], zero pad
);

  item_t   item_in, item_q;
  result_t result_d, result_q;
  logic    in_valid, out_ready, step;

  always_comb begin
    item_in.kind       = kind_e'(s_axis_tuser);
    item_in.reg_index  = s_axis_tdata[3:0];
    item_in.write_data = s_axis_tdata[19:4];
  end

  ptwp_stage #(.WIDTH($bits(item_t))) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (item_in),
    .valid_o (in_valid),
    .ready_i (out_ready),
    .data_o  (item_q)
  );

  assign step = in_valid & out_ready;

  ptwp_core #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .result_o (result_d)
  );

  ptwp_stage #(.WIDTH($bits(result_t))) u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .ready_o (out_ready),
    .data_i  (result_d),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (result_q)
  );

  assign m_axis_tdata = {4'b0, result_q};

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> m_axis_tvalid)
    else $error("processed item did not reach result register");

  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while result register empty");

  a_read_only_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && (result_d.read_data != 16'd0)) |-> (item_q.kind == KIND_READ))
    else $error("read data produced by non-read operation");

endmodule

`default_nettype wire
